@@ sv/h2r_pkg.sv @@
// Shared types and constants for the HSV to RGB converter pipeline.
`default_nettype none
package h2r_pkg;

    localparam int HueWidth   = 9;
    localparam int PctWidth   = 7;
    localparam int LevelWidth = 8;
    localparam int SvWidth    = 14;
    localparam int WeightWidth = 6;
    localparam int TermWidth  = 20;
    localparam int QuotWidth  = 18;
    localparam int ProdWidth  = 37;

    localparam logic [HueWidth-1:0] HueLimit   = 9'd360;
    localparam logic [PctWidth-1:0] PctLimit   = 7'd100;
    localparam logic [WeightWidth-1:0] SectorSpan = 6'd60;

    // Reciprocal of 625 scaled by 2^28, rounded up; exact for 18-bit dividends.
    localparam logic [18:0] RecipMult  = 19'd429497;
    localparam int          RecipShift = 28;

    typedef enum logic [2:0] {
        SECTOR_RED_YEL = 3'd0,
        SECTOR_YEL_GRN = 3'd1,
        SECTOR_GRN_CYN = 3'd2,
        SECTOR_CYN_BLU = 3'd3,
        SECTOR_BLU_MAG = 3'd4,
        SECTOR_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic                   err;
        sector_t                sector;
        logic [SvWidth-1:0]     sv;
        logic [SvWidth-1:0]     vd;
        logic [WeightWidth-1:0] weight;
    } prep_t;

    typedef struct packed {
        logic                 err;
        logic [TermWidth-1:0] comp_r;
        logic [TermWidth-1:0] comp_g;
        logic [TermWidth-1:0] comp_b;
        logic [TermWidth-1:0] offset;
    } terms_t;

endpackage
`default_nettype wire

@@ sv/h2r_prep.sv @@
// First stage: range check, hue sector, hue weight and the two small products.
`default_nettype none
module h2r_prep
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [h2r_pkg::HueWidth-1:0]  hue_degrees,
    input  wire logic [h2r_pkg::PctWidth-1:0]  saturation_pct,
    input  wire logic [h2r_pkg::PctWidth-1:0]  value_pct,
    output h2r_pkg::prep_t                     prep_reg
);

    h2r_pkg::prep_t             prep_next;
    logic [h2r_pkg::HueWidth-1:0] base;
    logic [6:0]                 hue_mod;
    logic [h2r_pkg::WeightWidth-1:0] hue_dist;
    logic [h2r_pkg::PctWidth-1:0] sat_rest;

    always_comb
    begin
        if (hue_degrees < 9'd120)
        begin
            base = 9'd0;
        end
        else if (hue_degrees < 9'd240)
        begin
            base = 9'd120;
        end
        else if (hue_degrees < h2r_pkg::HueLimit)
        begin
            base = 9'd240;
        end
        else
        begin
            base = h2r_pkg::HueLimit;
        end
        hue_mod = 7'(hue_degrees - base);
        if (hue_mod >= 7'd60)
        begin
            hue_dist = 6'(hue_mod - 7'd60);
        end
        else
        begin
            hue_dist = 6'(7'd60 - hue_mod);
        end

        if (hue_degrees < 9'd60)
        begin
            prep_next.sector = h2r_pkg::SECTOR_RED_YEL;
        end
        else if (hue_degrees < 9'd120)
        begin
            prep_next.sector = h2r_pkg::SECTOR_YEL_GRN;
        end
        else if (hue_degrees < 9'd180)
        begin
            prep_next.sector = h2r_pkg::SECTOR_GRN_CYN;
        end
        else if (hue_degrees < 9'd240)
        begin
            prep_next.sector = h2r_pkg::SECTOR_CYN_BLU;
        end
        else if (hue_degrees < 9'd300)
        begin
            prep_next.sector = h2r_pkg::SECTOR_BLU_MAG;
        end
        else
        begin
            prep_next.sector = h2r_pkg::SECTOR_MAG_RED;
        end

        sat_rest         = h2r_pkg::PctLimit - saturation_pct;
        prep_next.err    = (hue_degrees > h2r_pkg::HueLimit)
                           || (saturation_pct > h2r_pkg::PctLimit)
                           || (value_pct > h2r_pkg::PctLimit);
        prep_next.weight = h2r_pkg::SectorSpan - hue_dist;
        prep_next.sv     = h2r_pkg::SvWidth'(saturation_pct) * h2r_pkg::SvWidth'(value_pct);
        prep_next.vd     = h2r_pkg::SvWidth'(value_pct) * h2r_pkg::SvWidth'(sat_rest);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/h2r_terms.sv @@
// Second stage: chroma, secondary and offset numerators and sector routing.
`default_nettype none
module h2r_terms
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire h2r_pkg::prep_t prep,
    output h2r_pkg::terms_t     terms_reg
);

    h2r_pkg::terms_t              terms_next;
    logic [h2r_pkg::TermWidth-1:0] chroma;
    logic [h2r_pkg::TermWidth-1:0] second;
    logic [h2r_pkg::TermWidth-1:0] offset;

    always_comb
    begin
        chroma = h2r_pkg::TermWidth'(prep.sv) * 20'd60;
        second = h2r_pkg::TermWidth'(prep.sv) * h2r_pkg::TermWidth'(prep.weight);
        offset = h2r_pkg::TermWidth'(prep.vd) * 20'd60;

        terms_next.err    = prep.err;
        terms_next.comp_r = '0;
        terms_next.comp_g = '0;
        terms_next.comp_b = '0;
        terms_next.offset = offset;
        case (prep.sector)
            h2r_pkg::SECTOR_RED_YEL:
            begin
                terms_next.comp_r = chroma;
                terms_next.comp_g = second;
            end
            h2r_pkg::SECTOR_YEL_GRN:
            begin
                terms_next.comp_r = second;
                terms_next.comp_g = chroma;
            end
            h2r_pkg::SECTOR_GRN_CYN:
            begin
                terms_next.comp_g = chroma;
                terms_next.comp_b = second;
            end
            h2r_pkg::SECTOR_CYN_BLU:
            begin
                terms_next.comp_g = second;
                terms_next.comp_b = chroma;
            end
            h2r_pkg::SECTOR_BLU_MAG:
            begin
                terms_next.comp_r = second;
                terms_next.comp_b = chroma;
            end
            default:
            begin
                terms_next.comp_r = chroma;
                terms_next.comp_b = second;
            end
        endcase

        // An out-of-range word yields black.
        if (prep.err)
        begin
            terms_next.comp_r = '0;
            terms_next.comp_g = '0;
            terms_next.comp_b = '0;
            terms_next.offset = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/h2r_scale.sv @@
// Two stages that turn one channel numerator over 600000 into a byte.
`default_nettype none
module h2r_scale
(
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [h2r_pkg::TermWidth-1:0]   comp,
    input  wire logic [h2r_pkg::TermWidth-1:0]   offset,
    output logic [h2r_pkg::LevelWidth-1:0]       level
);

    logic [h2r_pkg::TermWidth:0]     sum;
    logic [25:0]                     scaled;
    logic [h2r_pkg::QuotWidth-1:0]   quot_next;
    logic [h2r_pkg::QuotWidth-1:0]   quot_reg;
    logic [h2r_pkg::ProdWidth-1:0]   prod_next;
    logic [h2r_pkg::ProdWidth-1:0]   prod_reg;

    // The product by 255/600000 is the product by 17/40000: a multiply by 17,
    // a shift by 6, then a reciprocal multiply for the division by 625.
    always_comb
    begin
        sum       = {1'b0, comp} + {1'b0, offset};
        scaled    = {1'b0, sum, 4'b0000} + 26'(sum);
        quot_next = scaled[23:6];
        prod_next = h2r_pkg::ProdWidth'(quot_reg) * h2r_pkg::ProdWidth'(h2r_pkg::RecipMult);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
            prod_reg <= prod_next;
        end
    end

    assign level = prod_reg[h2r_pkg::RecipShift +: h2r_pkg::LevelWidth];

endmodule
`default_nettype wire

@@ sv/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: four-stage pipeline and handshake.
`default_nettype none
// Converts one pixel word of hue (degrees), saturation and value (percent)
// into red, green and blue bytes, truncated exactly as the rational formula
// gives. A word is taken every cycle while the output side keeps taking
// results, and each accepted word passes in order through the four register
// stages: the range check and hue stage, the product stage, the scaling
// stage and the reciprocal multiply stage, whose register drives the outputs.
// When out_ready is low with a result waiting, the whole pipeline holds. A
// hue above 360 or a saturation or value above 100 gives black with
// range_error set.
module hsv_to_rgb_converter
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [h2r_pkg::HueWidth-1:0]    hue_degrees,
    input  wire logic [h2r_pkg::PctWidth-1:0]    saturation_pct,
    input  wire logic [h2r_pkg::PctWidth-1:0]    value_pct,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [h2r_pkg::LevelWidth-1:0]       red_level,
    output logic [h2r_pkg::LevelWidth-1:0]       green_level,
    output logic [h2r_pkg::LevelWidth-1:0]       blue_level,
    output logic                                 range_error
);

    logic            advance;
    logic [3:0]      valid_reg;
    logic [3:0]      valid_next;
    logic [1:0]      err_reg;
    logic [1:0]      err_next;
    h2r_pkg::prep_t  prep;
    h2r_pkg::terms_t terms;

    assign advance  = out_ready || !valid_reg[3];
    assign in_ready = advance;

    assign valid_next = {valid_reg[2:0], in_valid};
    assign err_next   = {err_reg[0], terms.err};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err_reg <= err_next;
        end
    end

    h2r_prep u_prep
    (
        .clk            (clk),
        .en             (advance),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .value_pct      (value_pct),
        .prep_reg       (prep)
    );

    h2r_terms u_terms
    (
        .clk       (clk),
        .en        (advance),
        .prep      (prep),
        .terms_reg (terms)
    );

    h2r_scale u_scale_r
    (
        .clk    (clk),
        .en     (advance),
        .comp   (terms.comp_r),
        .offset (terms.offset),
        .level  (red_level)
    );

    h2r_scale u_scale_g
    (
        .clk    (clk),
        .en     (advance),
        .comp   (terms.comp_g),
        .offset (terms.offset),
        .level  (green_level)
    );

    h2r_scale u_scale_b
    (
        .clk    (clk),
        .en     (advance),
        .comp   (terms.comp_b),
        .offset (terms.offset),
        .level  (blue_level)
    );

    assign out_valid   = valid_reg[3];
    assign range_error = err_reg[1];

endmodule
`default_nettype wire

@@ tb/sv/hsv_to_rgb_converter_tb.sv @@
// Self-checking testbench for the HSV to RGB converter with random handshake gaps.
module hsv_to_rgb_converter_tb;

    typedef struct packed {
        logic [h2r_pkg::HueWidth-1:0] hue;
        logic [h2r_pkg::PctWidth-1:0] sat;
        logic [h2r_pkg::PctWidth-1:0] val;
    } hsv_word_t;

    typedef struct packed {
        logic [h2r_pkg::LevelWidth-1:0] red;
        logic [h2r_pkg::LevelWidth-1:0] green;
        logic [h2r_pkg::LevelWidth-1:0] blue;
        logic                           err;
    } rgb_word_t;

    localparam int unsigned RatioDenom = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [h2r_pkg::HueWidth-1:0] hue_degrees = '0;
    logic [h2r_pkg::PctWidth-1:0] saturation_pct = '0;
    logic [h2r_pkg::PctWidth-1:0] value_pct = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [h2r_pkg::LevelWidth-1:0] red_level;
    logic [h2r_pkg::LevelWidth-1:0] green_level;
    logic [h2r_pkg::LevelWidth-1:0] blue_level;
    logic range_error;

    hsv_word_t pending_words[$];
    rgb_word_t rgb_due[$];

    logic word_taken = 1'b0;
    bit   quiet = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   words_total = 0;
    int   words_taken = 0;
    int   results_seen = 0;
    int   range_errors_seen = 0;
    int   mismatches = 0;

    hsv_to_rgb_converter dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .value_pct      (value_pct),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .range_error    (range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always
    begin
        repeat ($urandom_range(40, 400)) @(posedge clk);
        quiet = ~quiet;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [h2r_pkg::LevelWidth-1:0] level_of(int unsigned part,
                                                                 int unsigned offset);
        int unsigned scaled;
        scaled = (part + offset) * 255;
        return h2r_pkg::LevelWidth'(scaled / RatioDenom);
    endfunction

    function automatic rgb_word_t convert_hsv(hsv_word_t w);
        rgb_word_t        res;
        h2r_pkg::sector_t sector;
        int unsigned      chroma;
        int unsigned      second;
        int unsigned      offset;
        int unsigned      hue_mod;
        int unsigned      hue_dist;
        int unsigned      r;
        int unsigned      g;
        int unsigned      b;
        res = '0;
        if (w.hue > h2r_pkg::HueLimit || w.sat > h2r_pkg::PctLimit
            || w.val > h2r_pkg::PctLimit)
        begin
            res.err = 1'b1;
            return res;
        end
        chroma   = 60 * w.sat * w.val;
        hue_mod  = w.hue % 120;
        hue_dist = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
        second   = w.sat * w.val * (60 - hue_dist);
        offset   = 60 * w.val * (100 - w.sat);
        if (w.hue >= 300)
            sector = h2r_pkg::SECTOR_MAG_RED;
        else
            sector = h2r_pkg::sector_t'(w.hue / 60);
        case (sector)
            h2r_pkg::SECTOR_RED_YEL:
            begin
                r = chroma; g = second; b = 0;
            end
            h2r_pkg::SECTOR_YEL_GRN:
            begin
                r = second; g = chroma; b = 0;
            end
            h2r_pkg::SECTOR_GRN_CYN:
            begin
                r = 0;      g = chroma; b = second;
            end
            h2r_pkg::SECTOR_CYN_BLU:
            begin
                r = 0;      g = second; b = chroma;
            end
            h2r_pkg::SECTOR_BLU_MAG:
            begin
                r = second; g = 0;      b = chroma;
            end
            default:
            begin
                r = chroma; g = 0;      b = second;
            end
        endcase
        res.red   = level_of(r, offset);
        res.green = level_of(g, offset);
        res.blue  = level_of(b, offset);
        return res;
    endfunction

    task automatic queue_word(int h, int s, int v);
        hsv_word_t w;
        w.hue = h2r_pkg::HueWidth'(h);
        w.sat = h2r_pkg::PctWidth'(s);
        w.val = h2r_pkg::PctWidth'(v);
        pending_words.push_back(w);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !word_taken)
            begin
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() > 0)
            begin
                hsv_word_t w;
                w = pending_words.pop_front();
                hue_degrees    <= w.hue;
                saturation_pct <= w.sat;
                value_pct      <= w.val;
                in_valid       <= 1'b1;
                send_gap       <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end

            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        rgb_word_t want;
        hsv_word_t seen;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            word_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen.hue = hue_degrees;
                seen.sat = saturation_pct;
                seen.val = value_pct;
                rgb_due.push_back(convert_hsv(seen));
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (range_error)
                    range_errors_seen++;
                if (rgb_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d err %0d",
                             $time, red_level, green_level, blue_level, range_error);
                    mismatches++;
                end
                else
                begin
                    want = rgb_due.pop_front();
                    check_field("red_level", want.red, red_level);
                    check_field("green_level", want.green, green_level);
                    check_field("blue_level", want.blue, blue_level);
                    check_field("range_error", want.err, range_error);
                end
            end
        end
    end

    initial
    begin
        int hues[14];
        int pct_edges[4];
        int roll;

        hues      = '{0, 30, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360};
        pct_edges = '{0, 1, 99, 100};

        queue_word(0, 0, 0);
        queue_word(0, 100, 0);
        queue_word(0, 0, 100);
        foreach (hues[i])
            queue_word(hues[i], 100, 100);
        queue_word(90, 50, 75);
        queue_word(210, 37, 63);
        queue_word(330, 1, 1);
        queue_word(361, 50, 50);
        queue_word(0, 101, 50);
        queue_word(0, 50, 101);
        queue_word(360, 100, 101);
        queue_word(511, 127, 127);

        repeat (1400)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
                queue_word($urandom_range(360), $urandom_range(100), $urandom_range(100));
            else if (roll < 88)
                queue_word(hues[$urandom_range(13)], pct_edges[$urandom_range(3)],
                           pct_edges[$urandom_range(3)]);
            else
                queue_word($urandom_range(511), $urandom_range(127), $urandom_range(127));
        end
        words_total = pending_words.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_total || rgb_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d converted pixels, %0d of them flagged out of range.",
                 results_seen, range_errors_seen);
        $display("Hue covered every sector edge, with random gaps and output stalls.");
        if (mismatches == 0 && rgb_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", rgb_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule
